// ----- rtl/sfc_pkg.sv -----
// ---------------------------------------------------------------------------
// sfc_pkg
// Types, codes and the bytewise CRC-CCITT step shared by the frame checker.
// ---------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_BYTE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TYPE_MASK = 1'b1;

  localparam logic [7:0]  SYNC_BYTE_RST = 8'd170;
  localparam logic [7:0]  TYPE_MASK_RST = 8'd112;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd16;

  typedef enum logic [1:0] {
    STATUS_COMPLETE  = 2'd0,
    STATUS_BAD_SYNC  = 2'd1,
    STATUS_LEN_ERR   = 2'd2,
    STATUS_BAD_CRC   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [15:0] source_id;
    logic [31:0] second_count;
    logic [31:0] fraction_word;
  } result_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] type_mask;
  } cfg_t;

  // CRC-CCITT, poly 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  t;
    logic [7:0]  u;
    logic [15:0] u16;
    t   = crc[15:8] ^ b;
    u   = t ^ (t >> 4);
    u16 = {8'h00, u};
    return {crc[7:0], 8'h00} ^ u16 ^ (u16 << 5) ^ (u16 << 12);
  endfunction

endpackage

// ----- rtl/sfc_byte_if.sv -----
// ---------------------------------------------------------------------------
// sfc_byte_if
// Valid/ready channel carrying one received byte and its end-of-buffer flag.
// ---------------------------------------------------------------------------
interface sfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// ----- rtl/sfc_result_if.sv -----
// ---------------------------------------------------------------------------
// sfc_result_if
// Valid/ready channel carrying one frame status request with its header fields.
// ---------------------------------------------------------------------------
interface sfc_result_if;
  logic             valid;
  logic             ready;
  sfc_pkg::status_e status;
  logic [7:0]       frame_type;
  logic [15:0]      frame_length;
  logic [15:0]      source_id;
  logic [31:0]      second_count;
  logic [31:0]      fraction_word;

  modport source (
    output valid, output status, output frame_type, output frame_length,
    output source_id, output second_count, output fraction_word, input ready
  );
  modport sink (
    input valid, input status, input frame_type, input frame_length,
    input source_id, input second_count, input fraction_word, output ready
  );
endinterface

// ----- rtl/synchrophasor_frame_checker_top.sv -----
// ---------------------------------------------------------------------------
// synchrophasor_frame_checker_top
// Bytewise C37.118-style frame checker: sync, type, length, CRC-CCITT status.
// ---------------------------------------------------------------------------
// The block takes one received byte per cycle unless stalled, and gives one
// status request per frame: complete, invalid sync, length mismatch or
// invalid checksum, with the frame type and declared length (zero on
// invalid sync) and, on a complete frame, id, second count and fraction
// word. A byte is registered on acceptance and worked on from the input
// register; its result, if any, is loaded into the result register when
// the core consumes the byte. Sustained rate is one byte per cycle when no
// result stalls, set by the bytewise CRC update and frame-state update on
// the registered byte. The input side keeps accepting while a result waits,
// and stalls only when a byte that produces a result meets a full, unread
// result register. After a result, remaining bytes up to the buffer end
// are dropped silently. sync_byte (index 0, reset 0xAA) and type_mask
// (index 1, reset 0x70) are written through the plain write port, by the
// user only while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module synchrophasor_frame_checker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [7:0]                      cfg_wdata_i,
  sfc_byte_if.sink                        in_if,
  sfc_result_if.source                    out_if
);

  // configuration registers
  sfc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte <= sfc_pkg::SYNC_BYTE_RST;
      cfg_q.type_mask <= sfc_pkg::TYPE_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfc_pkg::CFG_SYNC_BYTE: cfg_q.sync_byte <= cfg_wdata_i;
        sfc_pkg::CFG_TYPE_MASK: cfg_q.type_mask <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sfc_pkg::item_t   in_item;
  sfc_pkg::item_t   cur_item;
  logic             cur_valid;
  logic             step;
  logic             res_valid;
  sfc_pkg::result_t res;
  logic             out_free;
  sfc_pkg::result_t out_res;

  assign in_item.rx_byte    = in_if.rx_byte;
  assign in_item.buffer_end = in_if.buffer_end;

  // a byte without a result never waits on the output side
  assign step = cur_valid && (!res_valid || out_free);

  sfc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_item_i    (in_item),
    .in_ready_o   (in_if.ready),
    .take_i       (step),
    .item_valid_o (cur_valid),
    .item_o       (cur_item)
  );

  sfc_frame_core u_frame_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (cur_item),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_if.valid),
    .out_res_o   (out_res),
    .out_ready_i (out_if.ready)
  );

  assign out_if.status        = out_res.status;
  assign out_if.frame_type    = out_res.frame_type;
  assign out_if.frame_length  = out_res.frame_length;
  assign out_if.source_id     = out_res.source_id;
  assign out_if.second_count  = out_res.second_count;
  assign out_if.fraction_word = out_res.fraction_word;

endmodule

// ----- rtl/sfc_in_stage.sv -----
// ---------------------------------------------------------------------------
// sfc_in_stage
// Input register: holds one accepted byte until the frame core consumes it.
// ---------------------------------------------------------------------------
module sfc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  sfc_pkg::item_t in_item_i,
  output logic           in_ready_o,
  input  logic           take_i,
  output logic           item_valid_o,
  output sfc_pkg::item_t item_o
);

  logic           valid_q;
  sfc_pkg::item_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ----- rtl/sfc_frame_core.sv -----
// ---------------------------------------------------------------------------
// sfc_frame_core
// Frame state: byte position, header capture, running and received CRC.
// ---------------------------------------------------------------------------
module sfc_frame_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfc_pkg::cfg_t    cfg_i,
  input  sfc_pkg::item_t   item_i,
  input  logic             step_i,
  output logic             res_valid_o,
  output sfc_pkg::result_t res_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] id_q, id_d;
  logic [31:0] sec_q, sec_d;
  logic [31:0] frac_q, frac_d;
  logic        discard_q, discard_d;

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic        emit;
    logic        crc_tail;
    b         = item_i.rx_byte;
    last      = item_i.buffer_end;
    emit      = 1'b0;
    crc_tail  = 1'b0;
    pos_d     = pos_q;
    len_d     = len_q;
    crc_d     = crc_q;
    rcrc_d    = rcrc_q;
    type_d    = type_q;
    id_d      = id_q;
    sec_d     = sec_q;
    frac_d    = frac_q;
    discard_d = discard_q;
    res_o     = '0;

    if (!discard_q) begin
      if (pos_q == 16'd0 && b != cfg_i.sync_byte) begin
        emit         = 1'b1;
        res_o.status = sfc_pkg::STATUS_BAD_SYNC;
      end else begin
        if (pos_q == 16'd1) begin
          type_d = b & cfg_i.type_mask;
        end else if (pos_q == 16'd2) begin
          len_d = {b, 8'h00};
        end else if (pos_q == 16'd3) begin
          len_d = {len_q[15:8], b};
        end else if (pos_q == 16'd4 || pos_q == 16'd5) begin
          id_d = {id_q[7:0], b};
        end else if (pos_q >= 16'd6 && pos_q <= 16'd9) begin
          sec_d = {sec_q[23:0], b};
        end else if (pos_q >= 16'd10 && pos_q <= 16'd13) begin
          frac_d = {frac_q[23:0], b};
        end

        // last two declared bytes are the trailing CRC
        crc_tail = (pos_q >= 16'd4) && (({1'b0, pos_q} + 17'd2) >= {1'b0, len_d});
        if (crc_tail) begin
          rcrc_d = {rcrc_q[7:0], b};
        end else begin
          crc_d = sfc_pkg::crc_step(crc_q, b);
        end

        res_o.frame_type   = type_d;
        res_o.frame_length = len_d;
        if (pos_q == 16'd3 && len_d < sfc_pkg::MIN_FRAME_LEN) begin
          emit         = 1'b1;
          res_o.status = sfc_pkg::STATUS_LEN_ERR;
        end else if (pos_q >= 16'd4 && ({1'b0, pos_q} + 17'd1) == {1'b0, len_d}) begin
          emit = 1'b1;
          if (rcrc_d == crc_d) begin
            res_o.status        = sfc_pkg::STATUS_COMPLETE;
            res_o.source_id     = id_d;
            res_o.second_count  = sec_d;
            res_o.fraction_word = frac_d;
          end else begin
            res_o.status = sfc_pkg::STATUS_BAD_CRC;
          end
        end else if (last) begin
          emit         = 1'b1;
          res_o.status = sfc_pkg::STATUS_LEN_ERR;
        end else begin
          pos_d = pos_q + 16'd1;
        end
      end
      if (emit && !last) begin
        discard_d = 1'b1;
      end
    end

    // buffer end always restarts for the next buffer
    if (last) begin
      pos_d     = '0;
      len_d     = '0;
      crc_d     = sfc_pkg::CRC_INIT;
      rcrc_d    = '0;
      type_d    = '0;
      id_d      = '0;
      sec_d     = '0;
      frac_d    = '0;
      discard_d = 1'b0;
    end

    res_valid_o = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      crc_q     <= sfc_pkg::CRC_INIT;
      rcrc_q    <= '0;
      type_q    <= '0;
      id_q      <= '0;
      sec_q     <= '0;
      frac_q    <= '0;
      discard_q <= 1'b0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      len_q     <= len_d;
      crc_q     <= crc_d;
      rcrc_q    <= rcrc_d;
      type_q    <= type_d;
      id_q      <= id_d;
      sec_q     <= sec_d;
      frac_q    <= frac_d;
      discard_q <= discard_d;
    end
  end

endmodule

// ----- rtl/sfc_out_stage.sv -----
// ---------------------------------------------------------------------------
// sfc_out_stage
// Result register: holds one status request until the sink takes it.
// ---------------------------------------------------------------------------
module sfc_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sfc_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  output sfc_pkg::result_t out_res_o,
  input  logic             out_ready_i
);

  logic             valid_q;
  sfc_pkg::result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule
